@@ rtl/lcar_pkg.sv @@
`timescale 1ns / 1ps

package lcar_pkg;

    // field widths
    localparam int CODE_W     = 24;
    localparam int COUNTS_W   = 18;
    localparam int TARE_W     = 18;
    localparam int CAL_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // default converter frame length
    localparam int DATA_BITS_DEF = 24;

    // first divider: code / 100
    localparam int DIV_CONST = 100;
    localparam int REM1_W    = 7;

    // second divider: (200*d + c) / (20*c)
    localparam int NUM_MUL = 200;
    localparam int DEN_MUL = 20;
    localparam int NUM_W   = 26;
    localparam int DEN_W   = 12;

    // largest net weight
    localparam int NET_MAX = 167772;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL  = 2'd1;

    localparam logic [CAL_W-1:0] CAL_RESET = 7'd44;

    // serial clock phase of the converter interface
    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_FINAL = 4'b1000
    } phase_t;

    // datapath sequencer
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV1 = 6'b000010,
        ST_CHK  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV2 = 6'b010000,
        ST_FIN  = 6'b100000
    } ctrl_t;

endpackage

@@ rtl/load_cell_adc_readout_scaler.sv @@
`timescale 1ns / 1ps

// Bit-banged readout of a serial load cell converter. Each request is one SCK half period
// carrying the sampled DOUT level, and each request yields exactly one response with the
// SCK level to drive, the frame flag, the offset-binary code, the code divided by 100 and
// the net weight in grams. Ordinary ticks answer in the cycle after acceptance. The tick
// that completes a frame runs two bit-serial restoring dividers, one quotient bit per
// cycle: first a DATA_BITS-bit divide by 100, then the tare check and numerator set-up,
// then a 26-bit divide by 20*cal; the frame response is presented from the final state.
// When the reading is not above tare, or cal is zero, the second divide is skipped. A
// stalled response holds the sequencer in its final state. Only one request is in flight
// at a time; a new one is taken as soon as the sequencer is idle and the response
// register is empty or being drained. tare_counts (index 0) and cal_tenths (index 1) are
// written through the cfg port; the user must write them only while the block is idle,
// which the block itself does not enforce; other indexes are ignored.
module load_cell_adc_readout_scaler #(
    parameter int DATA_BITS = lcar_pkg::DATA_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_dout_level,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_sck_level,
    output logic                             m_frame_done,
    output logic [lcar_pkg::CODE_W-1:0]      m_raw_code,
    output logic [lcar_pkg::COUNTS_W-1:0]    m_scaled_counts,
    output logic [lcar_pkg::COUNTS_W-1:0]    m_net_weight
);

    localparam int CNT_W  = $clog2(DATA_BITS + 1);
    localparam int STEP_W = $clog2(lcar_pkg::NUM_W + 1);
    localparam logic [DATA_BITS-1:0] TOP_BIT = DATA_BITS'(1) << (DATA_BITS - 1);

    // configuration registers
    logic [lcar_pkg::TARE_W-1:0] tare_reg;
    logic [lcar_pkg::CAL_W-1:0]  cal_reg;

    // converter interface state
    lcar_pkg::phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]            bit_count_reg, bit_count_next;
    logic [DATA_BITS-1:0]        shift_reg, shift_next;
    logic [lcar_pkg::COUNTS_W-1:0] held_reg, held_next;

    // sequencer and datapath
    lcar_pkg::ctrl_t             ctrl_reg, ctrl_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [DATA_BITS-1:0]        div1_reg, div1_next;
    logic [lcar_pkg::REM1_W-1:0] rem1_reg, rem1_next;
    logic [lcar_pkg::COUNTS_W-1:0] diff_reg, diff_next;
    logic                        upd_reg, upd_next;
    logic [lcar_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [lcar_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [lcar_pkg::DEN_W-1:0]  rem2_reg, rem2_next;

    // response register
    logic                        m_valid_reg, m_valid_next;
    logic                        sck_reg, sck_next;
    logic                        done_reg, done_next;
    logic [lcar_pkg::CODE_W-1:0] raw_reg, raw_next;
    logic [lcar_pkg::COUNTS_W-1:0] scaled_reg, scaled_next;
    logic [lcar_pkg::COUNTS_W-1:0] net_reg, net_next;

    logic                        slot_free;
    logic                        s_accept;
    logic [lcar_pkg::REM1_W:0]   trial1;
    logic [lcar_pkg::DEN_W:0]    trial2;
    logic [lcar_pkg::COUNTS_W-1:0] quot1;
    logic [lcar_pkg::COUNTS_W-1:0] net_sat;

    assign cfg_ready = 1'b1;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (ctrl_reg == lcar_pkg::ST_IDLE) && slot_free;
    assign s_accept  = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_sck_level     = sck_reg;
    assign m_frame_done    = done_reg;
    assign m_raw_code      = raw_reg;
    assign m_scaled_counts = scaled_reg;
    assign m_net_weight    = net_reg;

    // one restoring step of each divider
    assign trial1 = {rem1_reg, div1_reg[DATA_BITS-1]};
    assign trial2 = {rem2_reg, num_reg[lcar_pkg::NUM_W-1]};
    assign quot1  = lcar_pkg::COUNTS_W'(div1_reg);

    // clamp of the second quotient
    assign net_sat = (num_reg > lcar_pkg::NUM_W'(lcar_pkg::NET_MAX))
                   ? lcar_pkg::COUNTS_W'(lcar_pkg::NET_MAX)
                   : lcar_pkg::COUNTS_W'(num_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg <= '0;
            cal_reg  <= lcar_pkg::CAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcar_pkg::REG_TARE: tare_reg <= cfg_data[lcar_pkg::TARE_W-1:0];
                lcar_pkg::REG_CAL:  cal_reg  <= cfg_data[lcar_pkg::CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // tick handling and sequencer
    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        held_next      = held_reg;
        ctrl_next      = ctrl_reg;
        step_next      = step_reg;
        div1_next      = div1_reg;
        rem1_next      = rem1_reg;
        diff_next      = diff_reg;
        upd_next       = upd_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem2_next      = rem2_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        sck_next       = sck_reg;
        done_next      = done_reg;
        raw_next       = raw_reg;
        scaled_next    = scaled_reg;
        net_next       = net_reg;

        case (ctrl_reg)
            lcar_pkg::ST_IDLE: begin
                if (s_accept) begin
                    // default response for an ordinary tick
                    m_valid_next = 1'b1;
                    sck_next     = 1'b0;
                    done_next    = 1'b0;
                    raw_next     = '0;
                    scaled_next  = '0;
                    net_next     = held_reg;
                    case (phase_reg)
                        lcar_pkg::PH_WAIT: begin
                            if (!s_dout_level) begin
                                bit_count_next = '0;
                                shift_next     = '0;
                                phase_next     = lcar_pkg::PH_HIGH;
                            end
                        end
                        lcar_pkg::PH_HIGH: begin
                            sck_next   = 1'b1;
                            phase_next = (bit_count_reg < CNT_W'(DATA_BITS))
                                       ? lcar_pkg::PH_LOW : lcar_pkg::PH_FINAL;
                        end
                        lcar_pkg::PH_LOW: begin
                            shift_next     = {shift_reg[DATA_BITS-2:0], s_dout_level};
                            bit_count_next = bit_count_reg + CNT_W'(1);
                            phase_next     = lcar_pkg::PH_HIGH;
                        end
                        default: begin
                            // frame complete: answer after the dividers
                            m_valid_next = 1'b0;
                            phase_next   = lcar_pkg::PH_WAIT;
                            div1_next    = shift_reg ^ TOP_BIT;
                            rem1_next    = '0;
                            step_next    = '0;
                            ctrl_next    = lcar_pkg::ST_DIV1;
                        end
                    endcase
                end
            end
            lcar_pkg::ST_DIV1: begin
                // one quotient bit of code / 100 per cycle
                if (trial1 >= (lcar_pkg::REM1_W + 1)'(lcar_pkg::DIV_CONST)) begin
                    rem1_next = lcar_pkg::REM1_W'(
                        trial1 - (lcar_pkg::REM1_W + 1)'(lcar_pkg::DIV_CONST));
                    div1_next = {div1_reg[DATA_BITS-2:0], 1'b1};
                end else begin
                    rem1_next = trial1[lcar_pkg::REM1_W-1:0];
                    div1_next = {div1_reg[DATA_BITS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DATA_BITS - 1)) begin
                    ctrl_next = lcar_pkg::ST_CHK;
                end
            end
            lcar_pkg::ST_CHK: begin
                // tare check
                diff_next = quot1 - tare_reg;
                upd_next  = (quot1 > tare_reg) && (cal_reg != '0);
                ctrl_next = ((quot1 > tare_reg) && (cal_reg != '0))
                          ? lcar_pkg::ST_MUL : lcar_pkg::ST_FIN;
            end
            lcar_pkg::ST_MUL: begin
                // numerator 200*d + c and denominator 20*c
                num_next  = lcar_pkg::NUM_W'(diff_reg) * lcar_pkg::NUM_W'(lcar_pkg::NUM_MUL)
                          + lcar_pkg::NUM_W'(cal_reg);
                den_next  = lcar_pkg::DEN_W'(cal_reg) * lcar_pkg::DEN_W'(lcar_pkg::DEN_MUL);
                rem2_next = '0;
                step_next = '0;
                ctrl_next = lcar_pkg::ST_DIV2;
            end
            lcar_pkg::ST_DIV2: begin
                // one quotient bit of the weight per cycle
                if (trial2 >= {1'b0, den_reg}) begin
                    rem2_next = lcar_pkg::DEN_W'(trial2 - {1'b0, den_reg});
                    num_next  = {num_reg[lcar_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    rem2_next = trial2[lcar_pkg::DEN_W-1:0];
                    num_next  = {num_reg[lcar_pkg::NUM_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(lcar_pkg::NUM_W - 1)) begin
                    ctrl_next = lcar_pkg::ST_FIN;
                end
            end
            default: begin
                // update held weight and present the frame response
                if (slot_free) begin
                    if (upd_reg) begin
                        held_next = net_sat;
                    end
                    m_valid_next = 1'b1;
                    sck_next     = 1'b0;
                    done_next    = 1'b1;
                    raw_next     = lcar_pkg::CODE_W'(shift_reg ^ TOP_BIT);
                    scaled_next  = quot1;
                    net_next     = upd_reg ? net_sat : held_reg;
                    upd_next     = 1'b0;
                    ctrl_next    = lcar_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lcar_pkg::PH_WAIT;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            held_reg      <= '0;
            ctrl_reg      <= lcar_pkg::ST_IDLE;
            upd_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            held_reg      <= held_next;
            ctrl_reg      <= ctrl_next;
            upd_reg       <= upd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // datapath and response payload
    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        div1_reg   <= div1_next;
        rem1_reg   <= rem1_next;
        diff_reg   <= diff_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem2_reg   <= rem2_next;
        sck_reg    <= sck_next;
        done_reg   <= done_next;
        raw_reg    <= raw_next;
        scaled_reg <= scaled_next;
        net_reg    <= net_next;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_BITS = lcar_pkg::DATA_BITS_DEF;
    localparam logic [lcar_pkg::CODE_W-1:0] TOP_BIT =
        lcar_pkg::CODE_W'(1) << (FRAME_BITS - 1);
    localparam int PHASE_TICKS = 200;
    localparam int HOLD_LEN = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS = 10;

    // indexes past the register map, which the block must ignore
    localparam logic [lcar_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [lcar_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SEND,
        MODE_RECV,
        MODE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                          sck;
        logic                          done;
        logic [lcar_pkg::CODE_W-1:0]   raw;
        logic [lcar_pkg::COUNTS_W-1:0] scaled;
        logic [lcar_pkg::COUNTS_W-1:0] net;
    } readout_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lcar_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lcar_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic s_dout_level = 1'b1;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_sck_level;
    logic                          m_frame_done;
    logic [lcar_pkg::CODE_W-1:0]   m_raw_code;
    logic [lcar_pkg::COUNTS_W-1:0] m_scaled_counts;
    logic [lcar_pkg::COUNTS_W-1:0] m_net_weight;

    // stimulus and scoreboard state
    logic       dout_backlog[$];
    readout_t   predicted_readouts[$];
    idle_mode_t idle_mode = MODE_NONE;
    bit         hold_arm = 1'b0;
    int         hold_cycles = 0;
    int         mismatch_count = 0;

    // shadow of the converter readout
    lcar_pkg::phase_t              rd_phase = lcar_pkg::PH_WAIT;
    logic [4:0]                    rd_bits = '0;
    logic [lcar_pkg::CODE_W-1:0]   rd_shift = '0;
    logic [lcar_pkg::COUNTS_W-1:0] rd_net = '0;
    logic [lcar_pkg::TARE_W-1:0]   cur_tare = '0;
    logic [lcar_pkg::CAL_W-1:0]    cur_cal = lcar_pkg::CAL_RESET;

    load_cell_adc_readout_scaler uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dout_level   (s_dout_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sck_level    (m_sck_level),
        .m_frame_done   (m_frame_done),
        .m_raw_code     (m_raw_code),
        .m_scaled_counts(m_scaled_counts),
        .m_net_weight   (m_net_weight)
    );

    always #1 aclk = ~aclk;

    // one tick of the readout sequence: sck level, frame completion, code, scaled counts and net weight
    function automatic readout_t advance_readout(input logic dout);
        readout_t                    r;
        logic [lcar_pkg::CODE_W-1:0] code;
        logic [lcar_pkg::CODE_W-1:0] quot;
        longint unsigned             diff;
        longint unsigned             grams;
        r = '0;
        case (rd_phase)
            lcar_pkg::PH_WAIT: begin
                if (!dout) begin
                    rd_bits = '0;
                    rd_shift = '0;
                    rd_phase = lcar_pkg::PH_HIGH;
                end
            end
            lcar_pkg::PH_HIGH: begin
                r.sck = 1'b1;
                rd_phase = (rd_bits < FRAME_BITS) ? lcar_pkg::PH_LOW : lcar_pkg::PH_FINAL;
            end
            lcar_pkg::PH_LOW: begin
                rd_shift = {rd_shift[lcar_pkg::CODE_W-2:0], dout};
                rd_bits = rd_bits + 5'd1;
                rd_phase = lcar_pkg::PH_HIGH;
            end
            default: begin
                code = rd_shift ^ TOP_BIT;
                quot = code / lcar_pkg::DIV_CONST;
                r.raw = code;
                r.scaled = quot[lcar_pkg::COUNTS_W-1:0];
                // weight only moves when the reading is above tare and cal is non-zero
                if (quot > cur_tare && cur_cal != '0) begin
                    diff = longint'(quot) - longint'(cur_tare);
                    grams = (lcar_pkg::NUM_MUL * diff + cur_cal) /
                            (lcar_pkg::DEN_MUL * longint'(cur_cal));
                    if (grams > lcar_pkg::NET_MAX) begin
                        grams = lcar_pkg::NET_MAX;
                    end
                    rd_net = grams[lcar_pkg::COUNTS_W-1:0];
                end
                r.done = 1'b1;
                rd_phase = lcar_pkg::PH_WAIT;
            end
        endcase
        r.net = rd_net;
        return r;
    endfunction

    // sender: offers queued ticks, predicts each accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_readouts.push_back(advance_readout(s_dout_level));
            end
            if (!s_valid || s_ready) begin
                if (dout_backlog.size() == 0) begin
                    s_valid <= 1'b0;
                end else if ((idle_mode == MODE_SEND && $urandom_range(99) < 65) ||
                             (idle_mode == MODE_BOTH && $urandom_range(99) < 12)) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_dout_level <= dout_backlog.pop_front();
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
        end else if (hold_arm && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
        end
    end

    // receiver: checks each delivered readout against the oldest prediction
    always @(posedge aclk) begin
        readout_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_readouts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected readout at %0t: sck %0b done %0b raw %h", $realtime,
                                 m_sck_level, m_frame_done, m_raw_code);
                    end
                end else begin
                    want = predicted_readouts.pop_front();
                    if (m_sck_level !== want.sck || m_frame_done !== want.done ||
                        m_raw_code !== want.raw || m_scaled_counts !== want.scaled ||
                        m_net_weight !== want.net) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("readout mismatch at %0t", $realtime);
                            $display("  expected sck %0b done %0b raw %h scaled %0d net %0d",
                                     want.sck, want.done, want.raw, want.scaled, want.net);
                            $display("  actual   sck %0b done %0b raw %h scaled %0d net %0d",
                                     m_sck_level, m_frame_done, m_raw_code, m_scaled_counts,
                                     m_net_weight);
                        end
                    end
                end
            end
            if (hold_arm && hold_cycles < HOLD_LEN) begin
                m_ready <= 1'b0;
            end else begin
                case (idle_mode)
                    MODE_RECV: m_ready <= ($urandom_range(99) >= 65);
                    MODE_BOTH: m_ready <= ($urandom_range(99) >= 12);
                    default:   m_ready <= 1'b1;
                endcase
            end
        end
    end

    // a conversion: dout high while busy, low to start, then clocked bits msb first
    task automatic queue_frame(input int unsigned gap, input logic [lcar_pkg::CODE_W-1:0] code);
        logic [lcar_pkg::CODE_W-1:0] bits;
        bits = code ^ TOP_BIT;
        repeat (gap) dout_backlog.push_back(1'b1);
        dout_backlog.push_back(1'b0);
        for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            dout_backlog.push_back(1'($urandom_range(1)));
            dout_backlog.push_back(bits[i]);
        end
        // extra pulse and completing low tick, dout ignored on both
        dout_backlog.push_back(1'($urandom_range(1)));
        dout_backlog.push_back(1'($urandom_range(1)));
    endtask

    task automatic drain();
        while (dout_backlog.size() != 0 || s_valid || predicted_readouts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lcar_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == lcar_pkg::REG_TARE) begin
            cur_tare = data[lcar_pkg::TARE_W-1:0];
        end else if (idx == lcar_pkg::REG_CAL) begin
            cur_cal = data[lcar_pkg::CAL_W-1:0];
        end
    endtask

    // timeout
    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int                unsigned tare_w;
        int                unsigned cal_w;
        int                unsigned gap;
        int                unsigned pick;
        int                phase_ticks;
        int                target;
        logic [lcar_pkg::CODE_W-1:0] code;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle ticks with dout high, full scale code, zero code at reset settings
        idle_mode = MODE_NONE;
        queue_frame(3, {lcar_pkg::CODE_W{1'b1}});
        queue_frame(0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin tare_w = 0;      cal_w = 10;  end
                1: begin tare_w = lcar_pkg::NET_MAX; cal_w = 100; end
                2: begin tare_w = 80000;  cal_w = 0;   end
                3: begin tare_w = 1000;   cal_w = 1;   end
                4: begin tare_w = 262143; cal_w = 127; end
                default: begin
                    tare_w = $urandom_range(lcar_pkg::NET_MAX);
                    cal_w = $urandom_range(100, 10);
                end
            endcase
            drain();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            write_register(lcar_pkg::REG_TARE, lcar_pkg::CFG_DATA_W'(tare_w));
            write_register(lcar_pkg::REG_CAL, {11'($urandom), 7'(cal_w)});
            if (ph == 2 || ph == 6) begin
                write_register(REG_SPARE_A, lcar_pkg::CFG_DATA_W'($urandom));
                write_register(REG_SPARE_B, lcar_pkg::CFG_DATA_W'($urandom));
            end
            idle_mode = idle_mode_t'(ph % 4);
            // receiver holds off while the sender keeps offering
            if (ph == 4) begin
                hold_arm = 1'b1;
            end

            phase_ticks = 0;
            while (phase_ticks < PHASE_TICKS) begin
                gap = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(2);
                pick = $urandom_range(7);
                if (pick == 0) begin
                    case ($urandom_range(3))
                        0: code = '0;
                        1: code = {lcar_pkg::CODE_W{1'b1}};
                        2: code = TOP_BIT;
                        default: code = ~TOP_BIT;
                    endcase
                end else if (pick <= 2) begin
                    // readings just around the tare
                    target = int'(tare_w) + int'($urandom_range(4)) - 2;
                    if (target < 0) target = 0;
                    if (target > lcar_pkg::NET_MAX) target = lcar_pkg::NET_MAX;
                    target = target * lcar_pkg::DIV_CONST +
                             int'($urandom_range(lcar_pkg::DIV_CONST - 1));
                    if (target > 24'hFFFFFF) target = 24'hFFFFFF;
                    code = lcar_pkg::CODE_W'(target);
                end else begin
                    code = lcar_pkg::CODE_W'($urandom);
                end
                queue_frame(gap, code);
                phase_ticks += gap + 3 + 2 * FRAME_BITS;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lcar_pkg.sv
rtl/load_cell_adc_readout_scaler.sv
verif/testbench.sv
